@@ design/scc_pkg.sv @@
// Package for the sorting conveyor controller: widths, state codes, setting defaults.
// No dependencies.
package scc_pkg;
    localparam int TIME_BITS = 32;
    localparam int N_SET     = 9;
    localparam int SET_W     = 13;
    localparam int DIV_W     = 24;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [SET_W-1:0]     t_set;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RUN  = 3'd1;
    localparam logic [2:0] ST_SORT = 3'd2;
    localparam logic [2:0] ST_ERR  = 3'd3;
    localparam logic [2:0] ST_TEST = 3'd4;

    localparam logic CFG_AUTO    = 1'b0;
    localparam logic CFG_SPACING = 1'b1;

    function automatic t_set set_default(input logic [3:0] idx);
        unique case (idx)
            4'd0, 4'd4: return 13'd90;
            4'd1, 4'd5: return 13'd0;
            4'd2, 4'd6: return 13'd500;
            4'd3:       return 13'd200;
            4'd7:       return 13'd250;
            4'd8:       return 13'd20;
            default:    return 13'd0;
        endcase
    endfunction

    typedef struct packed {
        logic        start;
        logic [23:0] dividend;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic [23:0] quotient;
    } t_div_rsp;
endpackage

@@ design/scc_divider.sv @@
// Restoring serial divider, one quotient bit per cycle, for the sort transit time.
// Depends on scc_pkg.
module scc_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  scc_pkg::t_div_req i_req,
    output scc_pkg::t_div_rsp o_rsp
);
    import scc_pkg::*;

    logic [DIV_W-1:0] r_q, n_q;
    logic [16:0]      r_rem, n_rem;
    logic [15:0]      r_den;
    logic [4:0]       r_cnt;
    logic             r_busy;
    logic [16:0]      w_trial;

    always_comb begin
        w_trial = {r_rem[15:0], r_q[DIV_W-1]};
        n_q     = {r_q[DIV_W-2:0], 1'b0};
        n_rem   = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem   = w_trial - {1'b0, r_den};
            n_q[0]  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'(DIV_W);
            r_q    <= i_req.dividend;
            r_rem  <= '0;
            r_den  <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd1) r_busy <= 1'b0;
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.quotient = r_q;
endmodule

@@ design/sorting_conveyor_controller.sv @@
// Sorting conveyor controller, top level: tick sequencer plus serial divider.
// Sequence per tick: S_WAIT, S_DIV, S_FIN; when a sort starts, S_OUT waits for the transit divide
// before S_FIN. A new tick is taken only once the previous one is computed (back in S_WAIT);
//   a result beat still waiting holds the next tick in S_FIN.
// Reset: synchronous active low; all settings return to defaults at once.
// Depends on scc_pkg and scc_divider.
module sorting_conveyor_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode_level,
    input  logic        i_mode_edge,
    input  logic        i_up_edge,
    input  logic        i_down_edge,
    input  logic        i_estop_request,
    input  logic        i_jam_flag,
    input  logic        i_remote_recent,
    input  logic [31:0] i_encoder_pulses,
    input  logic [15:0] i_belt_speed,
    input  logic        i_sensor_present,
    input  logic [1:0]  i_color_class,
    input  logic [1:0]  i_class_servo,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_machine_state,
    output logic        o_motor_run,
    output logic        o_servo_write,
    output logic [1:0]  o_servo_target,
    output logic [7:0]  o_servo_angle,
    output logic        o_detect_event,
    output logic [1:0]  o_detect_class,
    output logic        o_done_event,
    output logic [3:0]  o_menu_position,
    output logic [12:0] o_menu_value,
    output logic        o_value_saved
);
    import scc_pkg::*;

    typedef enum logic [1:0] {S_WAIT, S_DIV, S_FIN, S_OUT} t_seq;

    localparam t_time HALF = t_time'(1) << (TIME_BITS - 1);

    t_seq  r_seq;
    logic  r_auto;
    logic [15:0] r_spacing;
    logic [2:0]  r_mode;
    logic [1:0]  r_phase, r_srv;
    t_time r_now, r_deadline, r_ldt, r_lpoll, r_pst;
    logic [31:0] r_ldc;
    logic  r_first, r_pu, r_ign, r_ih, r_il, r_th, r_tld, r_menu_on;
    logic [3:0]  r_cur;
    t_set  r_sv [N_SET];
    t_set  r_wk [N_SET];

    logic  r_lvl, r_edge, r_up, r_dn, r_estop, r_jam, r_remote, r_pres;
    logic [31:0] r_pulses;
    logic [15:0] r_speed;
    logic [1:0]  r_cls, r_csrv;
    logic [DIV_W-1:0] r_transit;

    t_div_req w_req;
    t_div_rsp w_rsp;

    scc_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    // sort transit divide is needed only when sort phase 0 will be evaluated
    logic [2:0] w_mode_pre;
    logic       w_need_div;
    always_comb begin
        w_mode_pre = (r_estop && r_mode != ST_ERR) ? ST_ERR : r_mode;
        w_need_div = (w_mode_pre == ST_SORT) && (r_phase == 2'd0);
        w_req.start    = (r_seq == S_DIV) && w_need_div;
        w_req.dividend = 24'(r_sv[(r_srv == 2'd1) ? 4'd3 : 4'd7]) * 24'd1000;
        w_req.divisor  = (r_speed == 16'd0) ? 16'd100 : r_speed;
    end

    function automatic t_set adj(input logic [3:0] c, input t_set v0, input logic up);
        t_set v;
        v = v0;
        unique case (c)
            4'd0, 4'd1, 4'd4, 4'd5: begin
                if (up && v < 13'd180) v = v + 13'd1;
                if (!up && v > 13'd0)  v = v - 13'd1;
            end
            4'd2, 4'd6: begin
                if (up && v < 13'd5000) v = v + 13'd50;
                if (!up && v > 13'd50)  v = v - 13'd50;
            end
            4'd3, 4'd7: begin
                if (up && v < 13'd2000) v = v + 13'd5;
                if (!up && v > 13'd5)   v = v - 13'd5;
            end
            default: begin
                if (up && v < 13'd1000) v = v + 13'd1;
                if (!up && v > 13'd1)   v = v - 13'd1;
            end
        endcase
        return v;
    endfunction

    // one tick of the controller, evaluated in S_FIN
    logic [2:0] n_mode;
    logic [1:0] n_phase, n_srv;
    t_time n_deadline, n_ldt, n_lpoll, n_pst;
    logic [31:0] n_ldc;
    logic  n_first, n_ign, n_ih, n_il, n_th, n_tld, n_menu_on;
    logic [3:0] n_cur;
    logic  n_load, n_save;
    logic  n_wr, n_det, n_done, n_upw, n_dnw;
    logic [1:0] n_tgt, n_dcls;
    logic [7:0] n_ang;
    t_set  n_upv, n_dnv;
    logic  w_ok;
    logic [3:0] w_b;
    t_time w_dl;

    always_comb begin
        n_mode = w_mode_pre;
        n_phase = r_phase; n_srv = r_srv; n_deadline = r_deadline;
        n_ldt = r_ldt; n_lpoll = r_lpoll; n_pst = r_pst; n_ldc = r_ldc;
        n_first = r_first; n_ih = r_ih; n_il = r_il; n_th = r_th;
        n_tld = r_tld; n_menu_on = r_menu_on; n_cur = r_cur;
        n_load = 1'b0; n_save = 1'b0;
        n_wr = 1'b0; n_tgt = 2'd0; n_ang = 8'd0; n_det = 1'b0; n_dcls = 2'd0;
        n_done = 1'b0; n_upw = 1'b0; n_dnw = 1'b0; n_upv = '0; n_dnv = '0;
        w_ok = 1'b0; w_dl = r_deadline;
        w_b = (r_srv == 2'd1) ? 4'd0 : 4'd4;
        n_ign = r_ign & r_lvl;
        if (r_pu && r_lvl) n_ign = 1'b1;

        if (n_mode == ST_IDLE) begin
            if (n_ign) begin
            end else if (r_lvl) begin
                if (!r_ih) begin
                    n_pst = r_now; n_ih = 1'b1; n_il = 1'b0;
                end else if (!r_il && (r_now - r_pst) > t_time'(4000)) begin
                    n_mode = ST_TEST; n_load = 1'b1; n_menu_on = 1'b1; n_cur = 4'd0;
                    n_il = 1'b1;
                end
            end else if (r_ih) begin
                if (!r_il && (r_now - r_pst) > t_time'(100) && r_auto) n_mode = ST_RUN;
                n_ih = 1'b0;
            end
        end else if (r_edge && (n_mode == ST_RUN || n_mode == ST_ERR)) begin
            n_mode = ST_IDLE; n_ih = 1'b0; n_il = 1'b0;
            if (r_lvl) n_ign = 1'b1;
        end

        if (n_mode == ST_RUN) begin
            if ((r_now - r_lpoll) >= t_time'(100)) begin
                n_lpoll = r_now;
                if (r_speed == 16'd0) w_ok = r_first || (r_now - r_ldt) >= t_time'(2000);
                else w_ok = r_first || (r_pulses - r_ldc) >= {16'd0, r_spacing};
                if (w_ok && r_pres && r_cls != 2'd3) begin
                    n_first = 1'b0; n_ldc = r_pulses; n_ldt = r_now;
                    n_det = 1'b1; n_dcls = r_cls;
                    if (r_csrv == 2'd1 || r_csrv == 2'd2) begin
                        n_mode = ST_SORT; n_phase = 2'd0; n_srv = r_csrv;
                    end
                end
            end
        end else if (n_mode == ST_SORT) begin
            if (n_phase == 2'd0) begin
                w_dl = r_now + t_time'(r_transit);
                n_phase = 2'd1;
            end
            if (n_phase == 2'd1 && (r_now - w_dl) < HALF) begin
                if (!r_jam) begin
                    n_wr = 1'b1; n_tgt = r_srv; n_ang = r_sv[w_b + 4'd1][7:0];
                    w_dl = r_now + t_time'(r_sv[w_b + 4'd2]);
                    n_phase = 2'd2;
                end else begin
                    n_mode = ST_RUN; n_phase = 2'd0;
                end
            end
            if (n_phase == 2'd2 && (r_now - w_dl) < HALF) begin
                n_wr = 1'b1; n_tgt = r_srv; n_ang = r_sv[w_b][7:0];
                n_mode = ST_RUN; n_phase = 2'd0; n_done = 1'b1;
            end
            n_deadline = w_dl;
        end else if (n_mode == ST_TEST) begin
            if (!r_remote) begin
                if (!r_menu_on) begin
                    n_load = 1'b1; n_menu_on = 1'b1; n_cur = 4'd0;
                end
                if (r_lvl) begin
                    if (!r_th) begin
                        n_pst = r_now; n_th = 1'b1; n_tld = 1'b0;
                    end else if (!r_tld && (r_now - r_pst) > t_time'(3000)) begin
                        if (n_cur == 4'd9) begin
                            n_mode = ST_IDLE; n_menu_on = 1'b0;
                            n_ih = 1'b0; n_il = 1'b0; n_ign = 1'b1;
                        end else if (n_cur < 4'(N_SET)) begin
                            n_save = 1'b1;
                        end
                        n_tld = 1'b1;
                    end
                end else if (r_th) begin
                    if (!r_tld && (r_now - r_pst) > t_time'(100))
                        n_cur = (n_cur == 4'd9) ? 4'd0 : n_cur + 4'd1;
                    n_th = 1'b0;
                end
            end else begin
                n_menu_on = 1'b0;
            end
        end
    end

    // menu adjust uses the working value after any load
    t_set w_wv, w_wv2;
    always_comb begin
        w_wv = '0;
        if (n_cur < 4'(N_SET)) w_wv = n_load ? r_sv[n_cur] : r_wk[n_cur];
        w_wv2 = w_wv;
        if (n_mode == ST_TEST && !r_remote && n_cur < 4'(N_SET)) begin
            if (r_up) w_wv2 = adj(n_cur, w_wv2, 1'b1);
            if (r_dn) w_wv2 = adj(n_cur, w_wv2, 1'b0);
        end
    end

    logic w_adj, w_srvcur;
    assign w_adj = n_mode == ST_TEST && !r_remote && n_cur < 4'(N_SET) && (r_up || r_dn);
    assign w_srvcur = n_cur == 4'd0 || n_cur == 4'd1 || n_cur == 4'd4 || n_cur == 4'd5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= S_WAIT; o_valid <= 1'b0; r_auto <= 1'b1; r_spacing <= 16'd100;
            r_mode <= ST_IDLE; r_phase <= 2'd0; r_srv <= 2'd1; r_now <= '0;
            r_deadline <= '0; r_ldt <= '0; r_ldc <= '0; r_first <= 1'b1;
            r_lpoll <= '0; r_pst <= '0; r_pu <= 1'b1; r_ign <= 1'b0; r_ih <= 1'b0;
            r_il <= 1'b0; r_th <= 1'b0; r_tld <= 1'b0; r_menu_on <= 1'b0; r_cur <= 4'd0;
            for (int i = 0; i < N_SET; i++) begin
                r_sv[i] <= set_default(4'(i));
                r_wk[i] <= set_default(4'(i));
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_AUTO) r_auto <= i_cfg_data[0];
                else if (i_cfg_index == CFG_SPACING) r_spacing <= i_cfg_data;
            end
            unique case (r_seq)
                S_WAIT: if (i_valid) begin
                    r_lvl <= i_mode_level; r_edge <= i_mode_edge; r_up <= i_up_edge;
                    r_dn <= i_down_edge; r_estop <= i_estop_request; r_jam <= i_jam_flag;
                    r_remote <= i_remote_recent; r_pulses <= i_encoder_pulses;
                    r_speed <= i_belt_speed; r_pres <= i_sensor_present;
                    r_cls <= i_color_class; r_csrv <= i_class_servo;
                    r_seq <= S_DIV;
                end
                S_DIV: r_seq <= w_need_div ? S_OUT : S_FIN;
                S_OUT: if (!w_rsp.busy) begin
                    r_transit <= w_rsp.quotient;
                    r_seq <= S_FIN;
                end
                S_FIN: if (!o_valid || i_ready) begin
                    r_mode <= n_mode; r_phase <= n_phase; r_srv <= n_srv;
                    r_deadline <= n_deadline; r_ldt <= n_ldt; r_lpoll <= n_lpoll;
                    r_pst <= n_pst; r_ldc <= n_ldc; r_first <= n_first; r_pu <= 1'b0;
                    r_ign <= n_ign; r_ih <= n_ih; r_il <= n_il; r_th <= n_th;
                    r_tld <= n_tld; r_menu_on <= n_menu_on; r_cur <= n_cur;
                    r_now <= r_now + t_time'(1);
                    for (int i = 0; i < N_SET; i++) begin
                        if (w_adj && n_cur == 4'(i)) r_wk[i] <= w_wv2;
                        else if (n_load) r_wk[i] <= r_sv[i];
                        if (n_save && !n_load && n_cur == 4'(i)) r_sv[i] <= r_wk[i];
                    end
                    o_machine_state <= n_mode;
                    o_motor_run <= n_mode == ST_RUN || n_mode == ST_SORT;
                    o_detect_event <= n_det; o_detect_class <= n_dcls;
                    o_done_event <= n_done; o_menu_position <= n_cur;
                    o_menu_value <= (n_cur < 4'(N_SET)) ? (w_adj ? w_wv2 : w_wv) : '0;
                    o_value_saved <= n_save;
                    if (w_adj && w_srvcur) begin
                        o_servo_write <= 1'b1;
                        o_servo_target <= (n_cur < 4'd4) ? 2'd1 : 2'd2;
                        o_servo_angle <= w_wv2[7:0];
                    end else begin
                        o_servo_write <= n_wr; o_servo_target <= n_tgt; o_servo_angle <= n_ang;
                    end
                    o_valid <= 1'b1;
                    r_seq <= S_WAIT;
                end
                default: r_seq <= S_WAIT;
            endcase
            if (o_valid && i_ready && r_seq != S_FIN) o_valid <= 1'b0;
        end
    end

    assign o_ready = (r_seq == S_WAIT);

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == S_WAIT && $past(r_seq) == S_FIN) |-> o_valid) else $error("result lost");
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.busy |-> (r_seq == S_OUT)) else $error("divider busy outside wait");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !w_rsp.busy) else $error("ready while dividing");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_machine_state)
            && $stable(o_menu_value))) else $error("result beat changed while waiting");
endmodule
